// ===== src/ctf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctf_pkg;

  // default and upper bound of the arctangent iteration count
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries     = 24;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ACC_OFFSET_ROLL  = 3'd0,
    CFG_ACC_OFFSET_PITCH = 3'd1,
    CFG_GYRO_OFFSET_X    = 3'd2,
    CFG_GYRO_OFFSET_Y    = 3'd3,
    CFG_GYRO_OFFSET_Z    = 3'd4,
    CFG_BLEND_WEIGHT     = 3'd5,
    CFG_GYRO_COUNTS_DPS  = 3'd6
  } ctf_cfg_idx_e;

  localparam logic [16:0] BlendWeightReset = 17'd65274;
  localparam logic [10:0] GyroCountsReset  = 11'd1310;
  localparam logic [16:0] BlendWeightOne   = 17'd65536;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [15:0] elapsed_ms;
  } ctf_in_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
  } ctf_out_t;

  // completion flags of the five lanes
  typedef struct packed {
    logic roll;
    logic pitch;
    logic gyro_x;
    logic gyro_y;
    logic gyro_z;
  } ctf_lane_done_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:    r = 32'sd2949120;
      5'd1:    r = 32'sd1740967;
      5'd2:    r = 32'sd919879;
      5'd3:    r = 32'sd466945;
      5'd4:    r = 32'sd234378;
      5'd5:    r = 32'sd117304;
      5'd6:    r = 32'sd58666;
      5'd7:    r = 32'sd29335;
      5'd8:    r = 32'sd14668;
      5'd9:    r = 32'sd7334;
      5'd10:   r = 32'sd3667;
      5'd11:   r = 32'sd1833;
      5'd12:   r = 32'sd917;
      5'd13:   r = 32'sd458;
      5'd14:   r = 32'sd229;
      5'd15:   r = 32'sd115;
      5'd16:   r = 32'sd57;
      5'd17:   r = 32'sd29;
      5'd18:   r = 32'sd14;
      5'd19:   r = 32'sd7;
      5'd20:   r = 32'sd4;
      5'd21:   r = 32'sd2;
      5'd22:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ctf_tilt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctf_tilt_lane #(
  parameter int unsigned CordicStages = ctf_pkg::CordicStagesDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire signed  [16:0] num_i,
  input  wire signed  [16:0] a_i,
  input  wire signed  [16:0] b_i,
  input  wire signed  [23:0] offset_i,
  output logic signed [32:0] angle_o,
  output logic               done_o
);
  import ctf_pkg::*;

  localparam int unsigned NumIter = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

  typedef enum logic [1:0] {T_IDLE, T_SQRT, T_CORDIC, T_DONE} tstate_e;

  tstate_e            state_q;
  logic        [4:0]  cnt_q;
  logic        [47:0] v_q;
  logic        [47:0] res_q;
  logic signed [27:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic signed [32:0] angle_q;

  logic signed [33:0] sq_a, sq_b;
  logic        [31:0] sq_sum;
  logic        [47:0] bit_w, trial, v_d, res_d;
  logic               take;
  logic signed [27:0] dx, dy, x_d, y_d;
  logic signed [31:0] z_d, atan_i;
  logic signed [32:0] off_ext;

  // sum of squares of the two side axes
  assign sq_a   = a_i * a_i;
  assign sq_b   = b_i * b_i;
  assign sq_sum = sq_a[31:0] + sq_b[31:0];

  // one result bit of the square root per cycle
  assign bit_w = 48'd1 << {cnt_q, 1'b0};
  assign trial = res_q + bit_w;
  assign take  = (v_q >= trial);
  assign v_d   = take ? (v_q - trial) : v_q;
  assign res_d = take ? ((res_q >> 1) + bit_w) : (res_q >> 1);

  // one vectoring rotation per cycle
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_i = atan_deg(cnt_q);
  assign x_d    = (y_q >= 0) ? (x_q + dx) : (x_q - dx);
  assign y_d    = (y_q >= 0) ? (y_q - dy) : (y_q + dy);
  assign z_d    = (y_q >= 0) ? (z_q + atan_i) : (z_q - atan_i);

  assign off_ext = {{9{offset_i[23]}}, offset_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        T_SQRT: begin
          v_q   <= v_d;
          res_q <= res_d;
          if (cnt_q == 5'd0) begin
            x_q   <= {4'b0, res_d[23:0]};
            y_q   <= {{3{num_i[16]}}, num_i, 8'b0};
            z_q   <= '0;
            cnt_q <= '0;
            // both operands zero give a zero angle before the offset is subtracted
            if (res_d == 48'd0 && num_i == 17'sd0) begin
              angle_q <= -off_ext;
              state_q <= T_DONE;
            end else begin
              state_q <= T_CORDIC;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        T_CORDIC: begin
          x_q   <= x_d;
          y_q   <= y_d;
          z_q   <= z_d;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(NumIter - 1)) begin
            angle_q <= {z_d[31], z_d} - off_ext;
            state_q <= T_DONE;
          end
        end
        default: begin
          if (start_i) begin
            v_q     <= {sq_sum, 16'b0};
            res_q   <= '0;
            cnt_q   <= 5'd23;
            state_q <= T_SQRT;
          end
        end
      endcase
    end
  end

  assign angle_o = angle_q;
  assign done_o  = (state_q == T_DONE);

endmodule

`default_nettype wire

// ===== src/ctf_gyro_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctf_gyro_lane (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire signed  [15:0] raw_i,
  input  wire signed  [23:0] bias_i,
  input  wire         [15:0] ms_i,
  input  wire         [10:0] cpd_i,
  output logic signed [44:0] delta_o,
  output logic               done_o
);
  import ctf_pkg::*;

  typedef enum logic [1:0] {G_IDLE, G_MUL, G_DIV, G_DONE} gstate_e;

  gstate_e      state_q;
  logic [5:0]   cnt_q;
  logic [24:0]  mag_q;
  logic         neg_q;
  logic [17:0]  den_q;
  logic [49:0]  num_q;
  logic [17:0]  rem_q;

  logic signed [25:0] r8;
  logic        [25:0] r8_neg;
  logic        [10:0] cpd_eff;
  logic        [40:0] prod;
  logic        [18:0] rem_sh;
  logic               ge;
  logic signed [44:0] q_pos;

  // bias removal in raw counts with 8 fraction bits
  assign r8      = {{2{raw_i[15]}}, raw_i, 8'b0} - {{2{bias_i[23]}}, bias_i};
  assign r8_neg  = -r8;
  assign cpd_eff = (cpd_i == 11'd0) ? 11'd1 : cpd_i;

  assign prod   = {16'b0, mag_q} * {25'b0, ms_i};
  assign rem_sh = {rem_q, num_q[49]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        G_MUL: begin
          // numerator with half the divisor added for rounding
          num_q   <= {1'b0, prod, 8'b0} + {33'b0, den_q[17:1]};
          rem_q   <= '0;
          cnt_q   <= 6'd49;
          state_q <= G_DIV;
        end
        G_DIV: begin
          // restoring division, one quotient bit per cycle
          rem_q <= ge ? 18'(rem_sh - {1'b0, den_q}) : rem_sh[17:0];
          num_q <= {num_q[48:0], ge};
          if (cnt_q == 6'd0) begin
            state_q <= G_DONE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: begin
          if (start_i) begin
            neg_q   <= r8[25];
            mag_q   <= r8[25] ? r8_neg[24:0] : r8[24:0];
            den_q   <= 18'({7'b0, cpd_eff}) * 18'd100;
            state_q <= G_MUL;
          end
        end
      endcase
    end
  end

  assign q_pos   = {1'b0, num_q[43:0]};
  assign delta_o = neg_q ? -q_pos : q_pos;
  assign done_o  = (state_q == G_DONE);

endmodule

`default_nettype wire

// ===== src/ctf_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctf_merge (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire signed  [32:0] acc_roll_i,
  input  wire signed  [32:0] acc_pitch_i,
  input  wire signed  [44:0] delta_x_i,
  input  wire signed  [44:0] delta_y_i,
  input  wire signed  [44:0] delta_z_i,
  input  wire         [16:0] weight_i,
  output logic signed [31:0] roll_o,
  output logic signed [31:0] pitch_o,
  output logic signed [31:0] yaw_o,
  output logic               done_o
);
  import ctf_pkg::*;

  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic               stage_q, done_q;
  logic signed [63:0] pg_roll_q, pa_roll_q, pg_pitch_q, pa_pitch_q;
  logic signed [44:0] dz_q;

  logic        [16:0] w_eff;
  logic        [17:0] w_acc;
  logic signed [45:0] g_roll, g_pitch;
  logic signed [63:0] s_roll, s_pitch;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] s);
    logic signed [47:0] v;
    v = s[63:16];
    if (v[47:31] == {17{v[47]}}) begin
      return v[31:0];
    end else if (v[47]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // weight clamp and gyro path sums
  assign w_eff   = (weight_i > BlendWeightOne) ? BlendWeightOne : weight_i;
  assign w_acc   = {1'b0, BlendWeightOne} - {1'b0, w_eff};
  assign g_roll  = {{14{roll_q[31]}}, roll_q} + {delta_x_i[44], delta_x_i};
  assign g_pitch = {{14{pitch_q[31]}}, pitch_q} + {delta_y_i[44], delta_y_i};

  // rounded blend, ties towards plus infinity
  assign s_roll  = pg_roll_q + pa_roll_q + 64'sd32768;
  assign s_pitch = pg_pitch_q + pa_pitch_q + 64'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
      if (start_i) begin
        pg_roll_q  <= g_roll * $signed({1'b0, w_eff});
        pa_roll_q  <= acc_roll_i * $signed(w_acc);
        pg_pitch_q <= g_pitch * $signed({1'b0, w_eff});
        pa_pitch_q <= acc_pitch_i * $signed(w_acc);
        dz_q       <= delta_z_i;
      end
      if (stage_q) begin
        roll_q  <= sat32(s_roll);
        pitch_q <= sat32(s_pitch);
        yaw_q   <= yaw_q + dz_q[31:0];
      end
    end
  end

  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;
  assign done_o  = done_q;

endmodule

`default_nettype wire

// ===== src/complementary_tilt_filter_top.sv =====
// Complementary tilt filter: roll, pitch and yaw from six-axis IMU samples.
// Input channel in_valid_i / in_ready_o carries one sample request
// (three accelerometer axes, three gyro axes, elapsed milliseconds).
// Output channel out_valid_o / out_ready_i carries roll, pitch and yaw in
// Q16.16 degrees, one result per sample, in order.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready;
// write only while no sample is in flight.
// The result timing is set by the 50-step restoring divider of the gyro
// lanes; the square root plus arctangent lanes work in parallel with it.
// One sample is worked on at a time, so a new request is taken only once
// the previous result has been placed in the output register.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver still stalls when the next result is
// ready, the block holds it and takes no further request.
// Reset clears the angle state to zero and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module complementary_tilt_filter_top #(
  parameter int unsigned CordicStages = ctf_pkg::CordicStagesDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  ctf_pkg::ctf_in_t in_req_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output ctf_pkg::ctf_out_t      out_rsp_o,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire              [2:0] cfg_index_i,
  input  wire             [23:0] cfg_data_i
);
  import ctf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_RUN, S_MERGE, S_HOLD} state_e;

  state_e             state_q;
  ctf_in_t            in_q;
  ctf_out_t           out_q;
  logic               out_valid_q;
  logic signed [23:0] off_roll_q, off_pitch_q, gof_x_q, gof_y_q, gof_z_q;
  logic        [16:0] weight_q;
  logic        [10:0] cpd_q;

  ctf_lane_done_t     lane_done;
  logic               lanes_start, merge_start, merge_done, load_out;
  logic signed [32:0] acc_roll, acc_pitch;
  logic signed [44:0] dx, dy, dz;
  logic signed [31:0] roll, pitch, yaw;
  logic signed [16:0] neg_ax;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign lanes_start = (state_q == S_START);
  assign merge_start = (state_q == S_RUN) && (&lane_done);
  assign neg_ax      = -{in_q.acc_x[15], in_q.acc_x};
  assign load_out    = ((state_q == S_MERGE && merge_done) || state_q == S_HOLD)
                       && (!out_valid_q || out_ready_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_roll_q  <= '0;
      off_pitch_q <= '0;
      gof_x_q     <= '0;
      gof_y_q     <= '0;
      gof_z_q     <= '0;
      weight_q    <= BlendWeightReset;
      cpd_q       <= GyroCountsReset;
    end else if (cfg_valid_i) begin
      case (ctf_cfg_idx_e'(cfg_index_i))
        CFG_ACC_OFFSET_ROLL:  off_roll_q  <= cfg_data_i;
        CFG_ACC_OFFSET_PITCH: off_pitch_q <= cfg_data_i;
        CFG_GYRO_OFFSET_X:    gof_x_q     <= cfg_data_i;
        CFG_GYRO_OFFSET_Y:    gof_y_q     <= cfg_data_i;
        CFG_GYRO_OFFSET_Z:    gof_z_q     <= cfg_data_i;
        CFG_BLEND_WEIGHT:     weight_q    <= cfg_data_i[16:0];
        CFG_GYRO_COUNTS_DPS:  cpd_q       <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // sequencing and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_req_i;
            state_q <= S_START;
          end
        end
        S_START: state_q <= S_RUN;
        S_RUN: begin
          if (merge_start) begin
            state_q <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_done) begin
            state_q <= load_out ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.roll_deg  <= roll;
      out_q.pitch_deg <= pitch;
      out_q.yaw_deg   <= yaw;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // accelerometer tilt lanes
  ctf_tilt_lane #(.CordicStages(CordicStages)) u_tilt_roll (
    .clk_i, .rst_ni,
    .start_i  (lanes_start),
    .num_i    ({in_q.acc_y[15], in_q.acc_y}),
    .a_i      ({in_q.acc_x[15], in_q.acc_x}),
    .b_i      ({in_q.acc_z[15], in_q.acc_z}),
    .offset_i (off_roll_q),
    .angle_o  (acc_roll),
    .done_o   (lane_done.roll)
  );

  ctf_tilt_lane #(.CordicStages(CordicStages)) u_tilt_pitch (
    .clk_i, .rst_ni,
    .start_i  (lanes_start),
    .num_i    (neg_ax),
    .a_i      ({in_q.acc_y[15], in_q.acc_y}),
    .b_i      ({in_q.acc_z[15], in_q.acc_z}),
    .offset_i (off_pitch_q),
    .angle_o  (acc_pitch),
    .done_o   (lane_done.pitch)
  );

  // gyro increment lanes
  ctf_gyro_lane u_gyro_x (
    .clk_i, .rst_ni,
    .start_i (lanes_start),
    .raw_i   (in_q.rate_x),
    .bias_i  (gof_x_q),
    .ms_i    (in_q.elapsed_ms),
    .cpd_i   (cpd_q),
    .delta_o (dx),
    .done_o  (lane_done.gyro_x)
  );

  ctf_gyro_lane u_gyro_y (
    .clk_i, .rst_ni,
    .start_i (lanes_start),
    .raw_i   (in_q.rate_y),
    .bias_i  (gof_y_q),
    .ms_i    (in_q.elapsed_ms),
    .cpd_i   (cpd_q),
    .delta_o (dy),
    .done_o  (lane_done.gyro_y)
  );

  ctf_gyro_lane u_gyro_z (
    .clk_i, .rst_ni,
    .start_i (lanes_start),
    .raw_i   (in_q.rate_z),
    .bias_i  (gof_z_q),
    .ms_i    (in_q.elapsed_ms),
    .cpd_i   (cpd_q),
    .delta_o (dz),
    .done_o  (lane_done.gyro_z)
  );

  // blend and state update
  ctf_merge u_merge (
    .clk_i, .rst_ni,
    .start_i     (merge_start),
    .acc_roll_i  (acc_roll),
    .acc_pitch_i (acc_pitch),
    .delta_x_i   (dx),
    .delta_y_i   (dy),
    .delta_z_i   (dz),
    .weight_i    (weight_q),
    .roll_o      (roll),
    .pitch_o     (pitch),
    .yaw_o       (yaw),
    .done_o      (merge_done)
  );

endmodule

`default_nettype wire

// ===== src/ctf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctf_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire ctf_pkg::ctf_out_t out_rsp_o
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // a fresh result appears only as the block frees its input
  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while still busy");

endmodule

bind complementary_tilt_filter_top ctf_checker u_ctf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
